@@ design/rts_pkg.sv @@
// ============================================================================
// rts_pkg
// Shared types and codes for the register table with spill slots.
// ============================================================================
package rts_pkg;

    localparam int KEY_W    = 16;
    localparam int RIDX_W   = 3;
    localparam int SIDX_W   = 5;

    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_OWNER  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_SWAP  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]        mode;
        logic [KEY_W-1:0]  key;
        logic [RIDX_W-1:0] reg_select;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [RIDX_W-1:0] reg_index;
        logic              in_spill;
        logic [SIDX_W-1:0] slot_index;
        logic [1:0]        action;
        logic              is_new;
        logic [KEY_W-1:0]  owner_key;
        logic              owner_valid;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_WB,
        S_OUT
    } t_state;

endpackage

@@ design/rts_stream_if.sv @@
// ============================================================================
// rts_stream_if
// Valid/ready channel carrying one word of a given type.
// ============================================================================
interface rts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/register_table_with_spill.sv @@
// ============================================================================
// register_table_with_spill
// Binds value keys to registers, overflowing into spill slots.
// ============================================================================
// Usage: requests arrive on i_req (mode, key, reg_select); one response word
// per request leaves on o_rsp. The block handles one request at a time.
// A GET, FREE or LOOKUP scans the spill-slot owner memory one entry per
// cycle (NUM_SLOTS reads through a registered read port). After the read
// pipeline drains, the execute state decides and sets up the memory
// write-back, and the write-back state raises the response. An owner query
// skips the scan and goes straight to execute and write-back. The register
// file (owners, ages, owned flags) and the slot owned flags are flip-flops;
// the slot owner table is a synchronous memory that reset does not clear,
// guarded by the owned flags. After reset every register and slot is free.
// A stalled response is held in the output register; the next request is
// accepted in the same cycle the response word is taken.
// ============================================================================
module register_table_with_spill #(
    parameter int NUM_REGS  = 8,
    parameter int NUM_SLOTS = 32,
    parameter int KEY_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rts_stream_if.sink       i_req,
    rts_stream_if.source     o_rsp
);
    localparam int RW = (NUM_REGS  > 1) ? $clog2(NUM_REGS)  : 1;
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    rts_pkg::t_state r_state, n_state;

    logic [NUM_REGS-1:0]     r_owned;
    logic [KEY_BITS-1:0]     r_owner [NUM_REGS];
    logic [15:0]             r_age   [NUM_REGS];
    logic [NUM_SLOTS-1:0]    r_sowned;
    logic [KEY_BITS-1:0]     mem     [NUM_SLOTS];
    logic [KEY_BITS-1:0]     r_rdata;

    rts_pkg::t_req           r_req;
    logic [KEY_BITS-1:0]     r_key;
    logic [CW-1:0]           r_cnt;     // read address counter
    logic [SW-1:0]           r_radr;    // address of the data in r_rdata
    logic                    r_rvld;
    logic                    r_found;   // key found in a slot
    logic [SW-1:0]           r_fslot;
    logic [KEY_BITS-1:0]     r_fkey;
    logic                    r_we;
    logic [SW-1:0]           r_wadr;
    logic [KEY_BITS-1:0]     r_wdata;
    rts_pkg::t_rsp           r_rsp;
    logic                    r_ovld;

    // ------------------------------------------------------------------
    // register and slot-flag combinational searches (NUM_REGS parallel key compares)
    // ------------------------------------------------------------------
    logic              hit_reg;
    logic [RW-1:0]     hit_idx;
    logic              has_free;
    logic [RW-1:0]     free_idx;
    logic [RW-1:0]     old_idx;
    logic [15:0]       old_age;
    logic              any_slot;
    logic [SW-1:0]     low_slot;
    logic              free_slot_ok;
    logic [SW-1:0]     free_slot;

    always_comb begin
        hit_reg  = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        old_idx  = '0;
        old_age  = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (r_owned[i] && r_owner[i] == r_key) begin
                hit_reg = 1'b1;
                hit_idx = RW'(i);
            end
            if (!r_owned[i]) begin
                has_free = 1'b1;
                free_idx = RW'(i);
            end
        end
        for (int i = 0; i < NUM_REGS; i++) begin
            if (r_age[i] > old_age) begin
                old_age = r_age[i];
                old_idx = RW'(i);
            end
        end
        any_slot     = 1'b0;
        low_slot     = '0;
        free_slot_ok = 1'b0;
        free_slot    = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_sowned[i]) begin
                any_slot = 1'b1;
                low_slot = SW'(i);
            end else begin
                free_slot_ok = 1'b1;
                free_slot    = SW'(i);
            end
        end
    end

    wire scan_done = (r_cnt == CW'(NUM_SLOTS)) && !r_rvld;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rts_pkg::S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    if (i_req.data.mode == rts_pkg::MODE_OWNER) begin
                        n_state = rts_pkg::S_EXEC;
                    end else begin
                        n_state = rts_pkg::S_SCAN;
                    end
                end
            end
            rts_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = rts_pkg::S_EXEC;
                end
            end
            rts_pkg::S_EXEC: n_state = rts_pkg::S_WB;
            rts_pkg::S_WB:   n_state = rts_pkg::S_IDLE;
            default:         n_state = rts_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    always_comb begin
        i_req.ready = (r_state == rts_pkg::S_IDLE) && (!r_ovld || o_rsp.ready);
        o_rsp.valid = r_ovld;
        o_rsp.data  = r_rsp;
    end

    // ------------------------------------------------------------------
    // memory: one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_wadr] <= r_wdata;
        end
        r_rdata <= mem[r_cnt[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rts_pkg::S_IDLE;
            r_owned  <= '0;
            r_sowned <= '0;
            r_ovld   <= 1'b0;
            r_rvld   <= 1'b0;
            r_we     <= 1'b0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_owner[i] <= '0;
                r_age[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state != rts_pkg::S_EXEC) begin
                r_we <= 1'b0;
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                rts_pkg::S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req   <= i_req.data;
                        r_key   <= KEY_BITS'(i_req.data.key);
                        r_cnt   <= '0;
                        r_rvld  <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                rts_pkg::S_SCAN: begin
                    // issue reads, then check returned word against the key
                    if (r_cnt != CW'(NUM_SLOTS)) begin
                        r_radr <= r_cnt[SW-1:0];
                        r_cnt  <= r_cnt + CW'(1);
                        r_rvld <= 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                    end
                    if (r_rvld && !r_found && r_sowned[r_radr] && r_rdata == r_key) begin
                        r_found <= 1'b1;
                        r_fslot <= r_radr;
                        r_fkey  <= r_rdata;
                    end
                    // hold the lowest owned slot's owner for a FREE reload
                    if (r_rvld && r_radr == low_slot && r_req.mode == rts_pkg::MODE_FREE
                            && hit_reg) begin
                        r_fkey <= r_rdata;
                    end
                end
                rts_pkg::S_EXEC: begin
                    rts_pkg::t_rsp v_rsp;
                    logic          v_we;
                    v_rsp = '0;
                    v_we  = 1'b0;
                    unique case (r_req.mode)
                        rts_pkg::MODE_GET: begin
                            if (hit_reg) begin
                                v_rsp.reg_index = rts_pkg::RIDX_W'(hit_idx);
                                for (int i = 0; i < NUM_REGS; i++)
                                    if (r_owned[i] && r_age[i] != AGE_MAX)
                                        r_age[i] <= r_age[i] + 16'd1;
                            end else if (r_found) begin
                                v_rsp.reg_index  = rts_pkg::RIDX_W'(old_idx);
                                v_rsp.slot_index = rts_pkg::SIDX_W'(r_fslot);
                                v_rsp.is_new     = 1'b1;
                                r_owner[old_idx] <= r_fkey;
                                r_owned[old_idx] <= 1'b1;
                                if (r_owned[old_idx]) begin
                                    v_rsp.action = rts_pkg::ACT_SWAP;
                                    v_we    = 1'b1;
                                    r_wadr  <= r_fslot;
                                    r_wdata <= r_owner[old_idx];
                                end else begin
                                    v_rsp.action = rts_pkg::ACT_LOAD;
                                    r_sowned[r_fslot] <= 1'b0;
                                end
                                for (int i = 0; i < NUM_REGS; i++) begin
                                    if (RW'(i) == old_idx)
                                        r_age[i] <= 16'd1;
                                    else if (r_owned[i] && r_age[i] != AGE_MAX)
                                        r_age[i] <= r_age[i] + 16'd1;
                                end
                            end else if (!has_free && !free_slot_ok) begin
                                v_rsp.status = rts_pkg::ST_FULL;
                            end else begin
                                logic [RW-1:0] tgt;
                                tgt = has_free ? free_idx : old_idx;
                                if (!has_free) begin
                                    r_sowned[free_slot] <= 1'b1;
                                    v_we    = 1'b1;
                                    r_wadr  <= free_slot;
                                    r_wdata <= r_owner[old_idx];
                                    v_rsp.slot_index = rts_pkg::SIDX_W'(free_slot);
                                    v_rsp.action     = rts_pkg::ACT_STORE;
                                end
                                r_owned[tgt] <= 1'b1;
                                r_owner[tgt] <= r_key;
                                v_rsp.reg_index = rts_pkg::RIDX_W'(tgt);
                                v_rsp.is_new    = 1'b1;
                                for (int i = 0; i < NUM_REGS; i++) begin
                                    if (RW'(i) == tgt)
                                        r_age[i] <= 16'd1;
                                    else if (r_owned[i] && r_age[i] != AGE_MAX)
                                        r_age[i] <= r_age[i] + 16'd1;
                                end
                            end
                        end
                        rts_pkg::MODE_FREE: begin
                            if (hit_reg) begin
                                v_rsp.reg_index = rts_pkg::RIDX_W'(hit_idx);
                                r_age[hit_idx]  <= '0;
                                if (any_slot) begin
                                    r_owner[hit_idx]   <= r_fkey;
                                    r_sowned[low_slot] <= 1'b0;
                                    v_rsp.slot_index   = rts_pkg::SIDX_W'(low_slot);
                                    v_rsp.action       = rts_pkg::ACT_LOAD;
                                end else begin
                                    r_owned[hit_idx] <= 1'b0;
                                    r_owner[hit_idx] <= '0;
                                end
                            end else if (r_found) begin
                                r_sowned[r_fslot] <= 1'b0;
                                v_rsp.in_spill    = 1'b1;
                                v_rsp.slot_index  = rts_pkg::SIDX_W'(r_fslot);
                            end else begin
                                v_rsp.status = rts_pkg::ST_NOTFOUND;
                            end
                        end
                        rts_pkg::MODE_LOOKUP: begin
                            if (hit_reg) begin
                                v_rsp.reg_index = rts_pkg::RIDX_W'(hit_idx);
                            end else if (r_found) begin
                                v_rsp.in_spill   = 1'b1;
                                v_rsp.slot_index = rts_pkg::SIDX_W'(r_fslot);
                            end else begin
                                v_rsp.status = rts_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            if (32'(r_req.reg_select) >= 32'(NUM_REGS)) begin
                                v_rsp.status = rts_pkg::ST_NOTFOUND;
                            end else begin
                                v_rsp.reg_index = r_req.reg_select;
                                if (r_owned[RW'(r_req.reg_select)]) begin
                                    v_rsp.owner_key = rts_pkg::KEY_W'(
                                        r_owner[RW'(r_req.reg_select)]);
                                    v_rsp.owner_valid = 1'b1;
                                end
                            end
                        end
                    endcase
                    r_rsp <= v_rsp;
                    r_we  <= v_we;
                end
                rts_pkg::S_WB: begin
                    r_ovld <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rts_pkg::S_WB) |=> r_ovld)
        else $error("response not raised after write-back");
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rts_pkg::S_IDLE) |-> !i_req.ready)
        else $error("request taken while busy");
    a_we_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> $past(r_state) == rts_pkg::S_EXEC)
        else $error("slot write outside execute");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rts_pkg::S_SCAN) |-> r_cnt <= CW'(NUM_SLOTS))
        else $error("scan counter overran");

endmodule
